// ===== sv/lssoc_pkg.sv =====
// ----------------------------------------------------------------------------
// lssoc_pkg: shared definitions for the line substring occurrence counter
// Widths, register indexes, the character window types and the result type
// used by the window cells, the output buffer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lssoc_pkg;

   // Number of window cells, which is also the longest pattern that can match.
   localparam int MAX_PATTERN   = 8;
   localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam int CHAR_W        = 8;
   localparam int PATTERN_CHARS = 8;
   localparam int PATTERN_W     = PATTERN_CHARS * CHAR_W;
   localparam int LENGTH_W      = 4;
   localparam int COUNT_W       = 32;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CHAR_W-1:0]      NEWLINE_CHAR = 8'd10;
   localparam logic [COUNT_W-1:0]     COUNT_MAX    = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 1'b1;

   localparam logic [PATTERN_W-1:0]   PATTERN_BYTES_RESET  = '0;
   localparam logic [LENGTH_W-1:0]    PATTERN_LENGTH_RESET = 4'd1;

   // One window position: the character and whether it belongs to the line.
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] ch;
   } cell_data_type;

   // Control shared by every cell of the window.
   typedef struct packed {
      logic shift;   // a byte is transferred in this cycle
      logic flush;   // the byte is a newline, the window empties
   } cell_ctrl_type;

   typedef struct packed {
      logic               match_here;
      logic [COUNT_W-1:0] occurrence_count;
   } result_type;

   // Pattern character at position idx; positions past the register read as 0.
   function automatic logic [CHAR_W-1:0] pattern_char(
      input logic [PATTERN_W-1:0] bytes,
      input logic [IDX_W-1:0]     idx
   );
      logic [PATTERN_W-1:0] shifted;
      shifted = bytes >> (CHAR_W * int'(idx));
      return shifted[CHAR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/lssoc_cell.sv =====
// ----------------------------------------------------------------------------
// lssoc_cell: one position of the character window
// Holds one character of the current line, takes its neighbour's character
// on every transfer and compares its new content with its pattern character.
// ----------------------------------------------------------------------------
`default_nettype none

module lssoc_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lssoc_pkg::cell_ctrl_type      ctrl,
   input  wire lssoc_pkg::cell_data_type      prev,
   input  wire logic [lssoc_pkg::CHAR_W-1:0]  pattern_ch,
   input  wire logic                          active,
   output lssoc_pkg::cell_data_type           held,
   output logic                               ok
);

   lssoc_pkg::cell_data_type cell_in;
   logic                     valid_ff;
   logic [lssoc_pkg::CHAR_W-1:0] ch_ff;

   always_comb begin
      cell_in.valid = prev.valid & ~ctrl.flush;
      cell_in.ch    = prev.ch;
      // A cell outside the pattern length never blocks a match.
      ok = ~active | (cell_in.valid & (cell_in.ch == pattern_ch));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         ch_ff <= cell_in.ch;
      end
   end

   assign held.valid = valid_ff;
   assign held.ch    = ch_ff;

endmodule

`default_nettype wire

// ===== sv/lssoc_out_buf.sv =====
// ----------------------------------------------------------------------------
// lssoc_out_buf: two-entry result buffer
// An output register with a skid register behind it, so that a result can be
// taken in while the previous one is still held by the receiving side.
// ----------------------------------------------------------------------------
`default_nettype none

module lssoc_out_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire lssoc_pkg::result_type  in_data,
   output logic                        full,
   output logic                        out_valid,
   output lssoc_pkg::result_type       out_data,
   input  wire logic                   out_stall
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   lssoc_pkg::result_type main_ff, main_in;
   lssoc_pkg::result_type skid_ff, skid_in;
   logic                  pop;

   always_comb begin
      pop           = main_valid_ff & ~out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No input is taken while the skid register is occupied.
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

// ===== sv/line_substring_occurrence_counter_top.sv =====
// ----------------------------------------------------------------------------
// line_substring_occurrence_counter_top: streaming substring counter
// Counts overlapping occurrences of a 1 to 8 character pattern in a byte
// stream, restarting the match window at every newline.
// ----------------------------------------------------------------------------
// Unless stalled, the block takes one text byte per cycle on the req_ channel
// and returns, for every byte, a registered result on the rsp_ channel:
// a flag saying whether the last pattern_length characters of the current
// line equal the pattern, and the running match count, which saturates at
// its maximum. A newline byte empties the window and gives a clear flag with
// the count unchanged; first_of_file clears both the window and the count
// before its byte is handled. Throughput is one byte per cycle when not
// stalled, set by the row of window cells that shift and compare together
// and by the count update; the result buffer holds two results, so input
// keeps flowing after the result side starts to stall. Registers must be
// written through the csr_ port only while the block is idle; it does not
// enforce this; pattern_length zero acts as one and above eight as eight.
`default_nettype none

module line_substring_occurrence_counter_top (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lssoc_pkg::CHAR_W-1:0]        req_char_in,
   input  wire logic                                req_first_of_file,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_match_here,
   output logic [lssoc_pkg::COUNT_W-1:0]            rsp_occurrence_count,

   input  wire logic                                csr_write_enable,
   input  wire logic [lssoc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lssoc_pkg::PATTERN_W-1:0]     csr_write_data
);

   localparam int N = lssoc_pkg::MAX_PATTERN;
   localparam int W = lssoc_pkg::IDX_W;

   // Configuration registers.
   logic [lssoc_pkg::PATTERN_W-1:0] pattern_bytes_ff;
   logic [lssoc_pkg::LENGTH_W-1:0]  pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= lssoc_pkg::PATTERN_BYTES_RESET;
         pattern_length_ff <= lssoc_pkg::PATTERN_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lssoc_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_ff <= csr_write_data;
            end
            lssoc_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_write_data[lssoc_pkg::LENGTH_W-1:0];
            end
            default: begin
               pattern_bytes_ff <= pattern_bytes_ff;
            end
         endcase
      end
   end

   // Effective pattern length minus one, clamped to the window size.
   logic [W-1:0] last_idx;

   always_comb begin
      priority if (pattern_length_ff == '0) begin
         last_idx = '0;
      end else if (int'(pattern_length_ff) > N) begin
         last_idx = W'(N - 1);
      end else begin
         last_idx = W'(pattern_length_ff - 4'd1);
      end
   end

   // Input handshake and window control.
   logic                     accept;
   logic                     is_newline;
   logic                     buf_full;
   lssoc_pkg::cell_ctrl_type ctrl;

   assign req_stall  = buf_full;
   assign accept     = req_valid & ~buf_full;
   assign is_newline = (req_char_in == lssoc_pkg::NEWLINE_CHAR);
   assign ctrl.shift = accept;
   assign ctrl.flush = is_newline;

   // Row of window cells; cell 0 takes the newest character. Cell k is
   // compared with the pattern character that lies k places before the
   // last one, and only cells within the current length take part.
   lssoc_pkg::cell_data_type held  [N];
   lssoc_pkg::cell_data_type prev  [N];
   logic [N-1:0]             cell_ok;

   for (genvar k = 0; k < N; k++) begin : g_cell
      logic                         active;
      logic [lssoc_pkg::CHAR_W-1:0] pch;

      if (k == 0) begin : g_head
         assign prev[k].valid = 1'b1;
         assign prev[k].ch    = req_char_in;
      end else begin : g_body
         // The start of a file drops whatever the window held.
         assign prev[k].valid = held[k-1].valid & ~req_first_of_file;
         assign prev[k].ch    = held[k-1].ch;
      end

      assign active = (last_idx >= W'(k));
      assign pch    = lssoc_pkg::pattern_char(pattern_bytes_ff, last_idx - W'(k));

      lssoc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev       (prev[k]),
         .pattern_ch (pch),
         .active     (active),
         .held       (held[k]),
         .ok         (cell_ok[k])
      );
   end

   // Running count, cleared at the start of a file and held at its maximum.
   logic [lssoc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lssoc_pkg::COUNT_W-1:0] count_base;
   logic                          hit;
   lssoc_pkg::result_type         result;
   lssoc_pkg::result_type         rsp_data;

   always_comb begin
      hit        = &cell_ok;
      count_base = req_first_of_file ? '0 : count_ff;
      if (hit && (count_base != lssoc_pkg::COUNT_MAX)) begin
         count_in = count_base + 1'b1;
      end else begin
         count_in = count_base;
      end
      result.match_here       = hit;
      result.occurrence_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   lssoc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_match_here       = rsp_data.match_here;
   assign rsp_occurrence_count = rsp_data.occurrence_count;

endmodule

`default_nettype wire
